@@ rtl/ffa_pkg.sv @@
// Shared codes and types for the first-fit free list allocator.
`default_nettype none

package ffa_pkg;

  // Result status codes
  localparam logic [1:0] ST_ALLOC   = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_FREE    = 2'd2;

  // Request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Header field picked by a read-modify-write patch
  typedef enum logic [1:0] {
    FLD_NEXT = 2'd0,
    FLD_PREV = 2'd1,
    FLD_SIZE = 2'd2,
    FLD_ALL  = 2'd3
  } ffa_field_t;

  // Compare flags of the shared arithmetic unit
  typedef struct packed {
    logic eq;
    logic ge;
  } ffa_flags_t;

endpackage

`default_nettype wire

@@ rtl/ffa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ffa_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 1025
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/ffa_alu.sv @@
// Shared add, subtract and compare unit used by the sequencer.
`default_nettype none

module ffa_alu
  import ffa_pkg::*;
#(
  parameter int W = 11
) (
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  output logic      [W:0]   sum,
  output logic      [W-1:0] diff,
  output ffa_flags_t        flags
);

  // Form sum, difference and magnitude flags
  always_comb begin
    sum      = {1'b0, a} + {1'b0, b};
    diff     = a - b;
    flags.eq = (a == b);
    flags.ge = (a >= b);
  end

endmodule

`default_nettype wire

@@ rtl/first_fit_free_list_allocator.sv @@
// Top level: sequencer of the first-fit free list allocator over a header RAM.
//
//  port group                      | dir | handshake
//  --------------------------------+-----+-----------------------------------
//  kind, request_bytes, block_addr | in  | transfer when start && !busy
//  status, result_addr             | out | transfer in the cycle done is high
//
// After reset a clearing pass writes the header RAM with busy high. An allocate
// walks the free list (S_A_FIRST, S_A_WALK); a grant that splits a block passes
// S_A_SPLIT, and each grant patches two headers by read-modify-write (S_P_RD,
// S_P_WR). A free walks the list to its place, reads the block and next headers,
// merges sizes (S_F_RDB to S_F_MERGE) and patches one or three headers. An
// invalid free answers without going busy. The strobe follows in the next cycle.
// Walks are paced by the single RAM read port: each node is one registered
// read. The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none

module first_fit_free_list_allocator
  import ffa_pkg::*;
#(
  parameter int ARENA_UNITS = 1024,
  parameter int UNIT_BYTES  = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       kind,
  input  wire logic [7:0] request_bytes,
  input  wire logic [9:0] block_addr,
  output logic            done,
  output logic [1:0]      status,
  output logic [9:0]      result_addr
);

  localparam int IW = $clog2(ARENA_UNITS + 1);
  localparam int VW = (IW > 9) ? IW : 9;
  localparam int HW = 3 * IW;
  localparam int SW = $clog2(2 * ARENA_UNITS + 5);
  localparam logic [IW-1:0] SENT       = IW'(ARENA_UNITS);
  localparam logic [SW-1:0] WALK_LAST  = SW'(2 * ARENA_UNITS + 3);

  typedef struct packed {
    logic [IW-1:0] next;
    logic [IW-1:0] prev;
    logic [IW-1:0] size;
  } hdr_t;

  typedef struct packed {
    logic [IW-1:0] addr;
    ffa_field_t    fld;
    hdr_t          val;
  } patch_t;

  typedef enum logic [11:0] {
    S_CLEAR   = 12'b000000000001,
    S_IDLE    = 12'b000000000010,
    S_A_FIRST = 12'b000000000100,
    S_A_WALK  = 12'b000000001000,
    S_A_SPLIT = 12'b000000010000,
    S_F_WALK  = 12'b000000100000,
    S_F_RDB   = 12'b000001000000,
    S_F_RDN   = 12'b000010000000,
    S_F_SUM   = 12'b000100000000,
    S_F_MERGE = 12'b001000000000,
    S_P_RD    = 12'b010000000000,
    S_P_WR    = 12'b100000000000
  } state_t;

  // Clamp an out-of-range link to the sentinel
  function automatic logic [IW-1:0] slot(input logic [VW:0] x);
    logic [IW-1:0] r;
    r = (x > (VW+1)'(ARENA_UNITS)) ? SENT : x[IW-1:0];
    return r;
  endfunction

  function automatic hdr_t mk(input logic [IW-1:0] n, input logic [IW-1:0] pv,
                              input logic [IW-1:0] s);
    hdr_t h;
    h.next = n;
    h.prev = pv;
    h.size = s;
    return h;
  endfunction

  state_t        state;
  logic [IW-1:0] clr;
  logic [IW-1:0] rover;
  logic [SW-1:0] steps;
  logic [VW-1:0] need;
  logic [IW-1:0] p;
  logic [IW-1:0] bp;
  logic [IW-1:0] nx;
  logic [IW-1:0] nn;
  logic [IW-1:0] hn_prev;
  logic [IW-1:0] hn_size;
  logic [IW-1:0] newsize;
  logic [IW-1:0] acc;
  hdr_t          hp;
  hdr_t          hb;
  logic          upper;
  logic          lower;
  patch_t        plist [3];
  logic [1:0]    pidx;
  logic [1:0]    plast;
  logic [1:0]    status_hold;
  logic [9:0]    res_hold;

  logic          we;
  logic [IW-1:0] waddr;
  logic [HW-1:0] wdata;
  logic [IW-1:0] raddr;
  logic [HW-1:0] rdata;
  hdr_t          rd;
  hdr_t          merged;
  logic [IW-1:0] nx_w;
  logic [IW-1:0] pv_w;
  logic          found;
  logic [VW-1:0] alu_a;
  logic [VW-1:0] alu_b;
  logic [VW:0]   alu_sum;
  logic [VW-1:0] alu_diff;
  ffa_flags_t    alu_f;

  assign busy = (state != S_IDLE);
  assign rd   = hdr_t'(rdata);
  assign nx_w = slot((VW+1)'(rd.next));
  assign pv_w = slot((VW+1)'(rd.prev));
  assign found = ((bp > p) && (bp < nx_w)) || ((p >= nx_w) && ((bp > p) || (bp < nx_w)));

  ffa_ram #(.WIDTH(HW), .DEPTH(ARENA_UNITS + 1)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  ffa_alu #(.W(VW)) u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .sum   (alu_sum),
    .diff  (alu_diff),
    .flags (alu_f)
  );

  // Pick the read address for the next cycle
  always_comb begin
    case (state)
      S_A_FIRST: raddr = nx_w;
      S_A_WALK:  raddr = nx_w;
      S_F_WALK:  raddr = found ? bp : nx_w;
      S_F_RDB:   raddr = nx;
      S_P_RD:    raddr = plist[pidx].addr;
      default:   raddr = rover;
    endcase
  end

  // Merge the patch into the header just read
  always_comb begin
    merged = rd;
    case (plist[pidx].fld)
      FLD_NEXT: merged.next = plist[pidx].val.next;
      FLD_PREV: merged.prev = plist[pidx].val.prev;
      FLD_SIZE: merged.size = plist[pidx].val.size;
      default:  merged = plist[pidx].val;
    endcase
  end

  // Drive the write port: clearing pass or patch write
  always_comb begin
    we    = 1'b0;
    waddr = clr;
    wdata = '0;
    if (state == S_CLEAR) begin
      we = 1'b1;
      if (clr == '0) begin
        wdata = HW'(mk(SENT, SENT, IW'(ARENA_UNITS - 1)));
      end else if (clr == SENT) begin
        wdata = '0;
      end
    end else if (state == S_P_WR) begin
      we    = 1'b1;
      waddr = plist[pidx].addr;
      wdata = HW'(merged);
    end
  end

  // Steer the shared unit
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    case (state)
      S_A_WALK: begin
        alu_a = VW'(rd.size);
        alu_b = need;
      end
      S_A_SPLIT: begin
        alu_a = VW'(p);
        alu_b = VW'(newsize);
      end
      S_F_RDB: begin
        alu_a = VW'(bp);
        alu_b = VW'(rd.size);
      end
      S_F_RDN: begin
        alu_a = VW'(p);
        alu_b = VW'(hp.size);
      end
      S_F_SUM: begin
        alu_a = VW'(hb.size);
        alu_b = VW'(hn_size);
      end
      S_F_MERGE: begin
        alu_a = upper ? VW'(acc) : VW'(hp.size);
        alu_b = upper ? (lower ? VW'(hp.size) : '0) : VW'(hb.size);
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
      rover <= SENT;
      done  <= 1'b0;
      pidx  <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          if (clr == SENT) begin
            state <= S_IDLE;
          end else begin
            clr <= clr + 1'b1;
          end
        end

        S_IDLE: begin
          if (start) begin
            need  <= VW'((16'(request_bytes) + 16'(UNIT_BYTES - 1)) / 16'(UNIT_BYTES) + 16'd1);
            bp    <= IW'(block_addr - 10'd1);
            p     <= rover;
            steps <= '0;
            if (kind == KIND_ALLOC) begin
              state <= S_A_FIRST;
            end else if ((block_addr != 10'd0) && (32'(block_addr) < ARENA_UNITS)) begin
              state <= S_F_WALK;
            end else begin
              status      <= ST_FREE;
              result_addr <= '0;
              done        <= 1'b1;
            end
          end
        end

        S_A_FIRST: begin
          p     <= nx_w;
          state <= S_A_WALK;
        end

        S_A_WALK: begin
          if (alu_f.ge) begin
            rover       <= pv_w;
            status_hold <= ST_ALLOC;
            if (alu_f.eq) begin
              plist[0] <= '{addr: pv_w, fld: FLD_NEXT, val: mk(nx_w, '0, '0)};
              plist[1] <= '{addr: nx_w, fld: FLD_PREV, val: mk('0, pv_w, '0)};
              plast    <= 2'd1;
              pidx     <= '0;
              res_hold <= 10'({1'b0, p} + 1'b1);
              state    <= S_P_RD;
            end else begin
              newsize <= IW'(alu_diff);
              state   <= S_A_SPLIT;
            end
          end else if ((p == rover) || (steps == WALK_LAST)) begin
            status      <= ST_NOSPACE;
            result_addr <= '0;
            done        <= 1'b1;
            state       <= S_IDLE;
          end else begin
            steps <= steps + 1'b1;
            p     <= nx_w;
          end
        end

        S_A_SPLIT: begin
          plist[0] <= '{addr: p, fld: FLD_SIZE, val: mk('0, '0, newsize)};
          plist[1] <= '{addr: slot(alu_sum), fld: FLD_SIZE, val: mk('0, '0, IW'(need))};
          plast    <= 2'd1;
          pidx     <= '0;
          res_hold <= 10'({1'b0, slot(alu_sum)} + 1'b1);
          state    <= S_P_RD;
        end

        S_F_WALK: begin
          if (found) begin
            hp    <= rd;
            nx    <= nx_w;
            state <= S_F_RDB;
          end else if (steps == WALK_LAST) begin
            status      <= ST_FREE;
            result_addr <= '0;
            done        <= 1'b1;
            state       <= S_IDLE;
          end else begin
            steps <= steps + 1'b1;
            p     <= nx_w;
          end
        end

        S_F_RDB: begin
          hb    <= rd;
          upper <= (alu_sum == (VW+1)'(nx));
          state <= S_F_RDN;
        end

        S_F_RDN: begin
          nn      <= nx_w;
          hn_prev <= pv_w;
          hn_size <= rd.size;
          lower   <= (alu_sum == (VW+1)'(bp));
          state   <= S_F_SUM;
        end

        S_F_SUM: begin
          acc   <= IW'(alu_sum);
          state <= S_F_MERGE;
        end

        S_F_MERGE: begin
          rover       <= p;
          status_hold <= ST_FREE;
          res_hold    <= '0;
          pidx        <= '0;
          state       <= S_P_RD;
          if (upper && lower) begin
            plist[0] <= '{addr: p,  fld: FLD_SIZE, val: mk('0, '0, IW'(alu_sum))};
            plist[1] <= '{addr: nn, fld: FLD_PREV, val: mk('0, p, '0)};
            plist[2] <= '{addr: p,  fld: FLD_NEXT, val: mk(nn, '0, '0)};
            plast    <= 2'd2;
          end else if (upper) begin
            plist[0] <= '{addr: bp, fld: FLD_ALL,  val: mk(nn, hn_prev, IW'(alu_sum))};
            plist[1] <= '{addr: nn, fld: FLD_PREV, val: mk('0, bp, '0)};
            plist[2] <= '{addr: p,  fld: FLD_NEXT, val: mk(bp, '0, '0)};
            plast    <= 2'd2;
          end else if (lower) begin
            plist[0] <= '{addr: p, fld: FLD_SIZE, val: mk('0, '0, IW'(alu_sum))};
            plast    <= 2'd0;
          end else begin
            plist[0] <= '{addr: bp, fld: FLD_ALL,  val: mk(nx, p, hb.size)};
            plist[1] <= '{addr: nx, fld: FLD_PREV, val: mk('0, bp, '0)};
            plist[2] <= '{addr: p,  fld: FLD_NEXT, val: mk(bp, '0, '0)};
            plast    <= 2'd2;
          end
        end

        S_P_RD: begin
          state <= S_P_WR;
        end

        S_P_WR: begin
          if (pidx == plast) begin
            status      <= status_hold;
            result_addr <= res_hold;
            done        <= 1'b1;
            state       <= S_IDLE;
          end else begin
            pidx  <= pidx + 1'b1;
            state <= S_P_RD;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start))
    else $error("result strobe without an item in flight");

  a_start_takes: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !(kind == KIND_FREE && (block_addr == 10'd0 ||
      32'(block_addr) >= ARENA_UNITS))) |=> busy)
    else $error("accepted item did not start the sequencer");

  a_rover_range: assert property (@(posedge clk) disable iff (rst)
    rover <= SENT)
    else $error("rover beyond sentinel");

  a_patch_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_P_RD || state == S_P_WR) |-> (pidx <= plast))
    else $error("patch index past list end");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_ALLOC || status == ST_NOSPACE || status == ST_FREE))
    else $error("bad status code");
`endif

endmodule

`default_nettype wire
